[design/assert_macros.svh]
// Assertion macros used by the checker file of the signature scanner.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition in post must hold in the same cycle as pre.
`define ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("check failed in the same cycle");

// The condition in post must hold in the cycle after pre.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("check failed one cycle later");

`endif

[design/wbss_pkg.sv]
// Shared types and constants of the wildcard byte signature scanner.
// No dependencies; every other design file but assert_macros.svh imports this package.
package wbss_pkg;

  localparam int unsigned PATTERN_BYTES_DEF = 8;
  localparam int unsigned PAT_W             = 64;
  localparam int unsigned MASK_W            = 8;
  localparam int unsigned LEN_W             = 4;
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned SEL_W             = 3;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 64;
  localparam logic [ADDR_W-1:0] OFFSET_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 3'd0,
    CFG_WILDCARD_MASK  = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_SCAN_LIMIT     = 3'd3,
    CFG_IMAGE_BASE     = 3'd4,
    CFG_PATTERN_OFFSET = 3'd5,
    CFG_ADDRESS_OFFSET = 3'd6,
    CFG_SUBTRACT_BASE  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
    logic       image_end;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
  } out_word_t;

  // Result request handed from the scan front end to the output pipeline.
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] start_off;
  } hit_t;

endpackage

[design/wildcard_byte_signature_scan_core.sv]
// Wildcard byte signature scanner, top level.
// Takes one image byte per cycle while not stalled; a result word passes through
// the pending register, then the output register. The input stalls only while a
// result waits in the output register and a second one is pending behind it.
// Reset (rst_ni low, asynchronous) clears the window, the offset counter, the
// scan state, the pipeline and sets the registers to their defaults.
module wildcard_byte_signature_scan_core import wbss_pkg::*; #(
  parameter int unsigned PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  localparam int unsigned NW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

  logic [PAT_W-1:0]  pattern_q;
  logic [MASK_W-1:0] mask_q;
  logic [LEN_W-1:0]  length_q;
  logic [ADDR_W-1:0] limit_q;
  logic [ADDR_W-1:0] base_q;
  logic [ADDR_W-1:0] pat_off_q;
  logic [ADDR_W-1:0] addr_off_q;
  logic              sub_base_q;
  logic [ADDR_W-1:0] addend_q;

  logic [ADDR_W-1:0] offset_q;
  logic              done_q;

  logic              accept;
  logic              start;
  logic              done_eff;
  logic              live;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] start_off;
  logic [NW-1:0]     last;
  logic              hit;
  logic              result;
  hit_t              req;

  logic [7:0]              win [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] cell_match;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= '0;
      mask_q     <= '0;
      length_q   <= LEN_W'(1);
      limit_q    <= '0;
      base_q     <= '0;
      pat_off_q  <= '0;
      addr_off_q <= '0;
      sub_base_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PATTERN_BYTES:  pattern_q  <= cfg_data_i[PAT_W-1:0];
        CFG_WILDCARD_MASK:  mask_q     <= cfg_data_i[MASK_W-1:0];
        CFG_PATTERN_LENGTH: length_q   <= cfg_data_i[LEN_W-1:0];
        CFG_SCAN_LIMIT:     limit_q    <= cfg_data_i[ADDR_W-1:0];
        CFG_IMAGE_BASE:     base_q     <= cfg_data_i[ADDR_W-1:0];
        CFG_PATTERN_OFFSET: pat_off_q  <= cfg_data_i[ADDR_W-1:0];
        CFG_ADDRESS_OFFSET: addr_off_q <= cfg_data_i[ADDR_W-1:0];
        CFG_SUBTRACT_BASE:  sub_base_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The constant part of the reported address only follows the registers.
  always_ff @(posedge clk_i) begin
    addend_q <= (sub_base_q ? '0 : base_q) + pat_off_q + addr_off_q;
  end

  // Index of the last signature byte in use, with the length clamped.
  always_comb begin
    if (length_q == '0) begin
      last = '0;
    end else if (length_q > LEN_W'(PATTERN_BYTES)) begin
      last = NW'(PATTERN_BYTES - 1);
    end else begin
      last = NW'(length_q - LEN_W'(1));
    end
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign start    = in_word_i.image_start;
  assign done_eff = done_q && !start;
  assign live     = accept && !done_eff;
  assign idx      = start ? '0 : offset_q;
  assign start_off = idx - ADDR_W'(last);

  for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
    if (k == 0) begin : g_head
      wbss_cell #(.IDX(k), .NW(NW)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (live),
        .clear_i   (1'b0),
        .byte_i    (in_word_i.data_byte),
        .pattern_i (pattern_q),
        .mask_i    (mask_q),
        .last_i    (last),
        .byte_o    (win[k]),
        .match_o   (cell_match[k])
      );
    end else begin : g_body
      wbss_cell #(.IDX(k), .NW(NW)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (live),
        .clear_i   (start),
        .byte_i    (win[k-1]),
        .pattern_i (pattern_q),
        .mask_i    (mask_q),
        .last_i    (last),
        .byte_o    (win[k]),
        .match_o   (cell_match[k])
      );
    end
  end

  // A window counts only when it is full, its last byte lies below the
  // saturation point and its start offset is under the scan limit.
  assign hit = live && (idx != OFFSET_MAX) && (idx >= ADDR_W'(last)) &&
               (start_off < limit_q) && (&cell_match);
  assign result = live && (hit || in_word_i.image_end);

  always_comb begin
    req.found     = hit;
    req.start_off = start_off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      done_q   <= 1'b0;
    end else if (accept) begin
      done_q <= done_eff || result;
      if (live) begin
        offset_q <= (idx == OFFSET_MAX) ? idx : idx + ADDR_W'(1);
      end
    end
  end

  wbss_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (result),
    .req_i       (req),
    .addend_i    (addend_q),
    .out_stall_i (out_stall_i),
    .stall_o     (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

[design/wbss_cell.sv]
// One window cell: holds one image byte, passes it on to the next cell and
// compares its next value against the signature byte that lines up with it.
// Depends on wbss_pkg.
module wbss_cell import wbss_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned NW  = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             clear_i,
  input  logic [7:0]       byte_i,
  input  logic [PAT_W-1:0] pattern_i,
  input  logic [MASK_W-1:0] mask_i,
  input  logic [NW-1:0]    last_i,
  output logic [7:0]       byte_o,
  output logic             match_o
);

  logic [7:0]       byte_q;
  logic [7:0]       byte_d;
  logic             active;
  logic [SEL_W-1:0] sel;

  assign byte_d = clear_i ? 8'h00 : byte_i;

  // The newest byte lines up with the last signature byte in use, so this
  // cell checks signature byte (last - IDX), last being the clamped length - 1.
  assign active  = (32'(last_i) >= IDX);
  assign sel     = SEL_W'(last_i - NW'(IDX));
  assign match_o = !active || mask_i[sel] || (byte_d == pattern_i[8*sel +: 8]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (shift_i) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

[design/wbss_result.sv]
// Result pipeline: holds a pending result, forms the reported address and keeps
// the output register. Drives the input stall. Depends on wbss_pkg.
module wbss_result import wbss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  hit_t              req_i,
  input  logic [ADDR_W-1:0] addend_i,
  input  logic              out_stall_i,
  output logic              stall_o,
  output logic              out_valid_o,
  output out_word_t         out_word_o
);

  logic      a_valid_q;
  hit_t      a_q;
  logic      b_valid_q;
  out_word_t b_q;
  out_word_t b_d;
  logic      b_free;
  logic      a_adv;

  assign b_free  = !b_valid_q || !out_stall_i;
  assign a_adv   = a_valid_q && b_free;
  assign stall_o = a_valid_q && !b_free;

  always_comb begin
    b_d.found   = a_q.found;
    b_d.address = a_q.found ? (a_q.start_off + addend_i) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (req_valid_i) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        b_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      a_q <= req_i;
    end
    if (a_adv) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_word_o  = b_q;

endmodule

[design/wbss_chk.sv]
// Port-level checks of the signature scanner, attached by the bind below.
// Depends on wbss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wbss_chk import wbss_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // A stalled result word stays valid and unchanged.
  `ASSERT_NEXT(out_hold_chk, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))

  // A scan that found nothing reports address zero.
  `ASSERT_NOW(miss_addr_chk, out_valid_o && !out_word_o.found, out_word_o.address == '0)

  // The input stalls only behind a result word that is itself held up.
  `ASSERT_NOW(stall_cause_chk, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind wildcard_byte_signature_scan_core wbss_chk u_wbss_chk (.*);
